// ===== hw/rtl/bbds_pkg.sv =====
// Shared types and constants for the box blur drop shadow block.
package bbds_pkg;

    localparam int ALPHA_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_CLAMP_CEILING = 2'd1
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST = 11'd1024;
    localparam logic [ALPHA_W-1:0]    CLAMP_RST       = 8'd225;

    // Output queue sizing; credits cover every item in flight plus the queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int CREDIT_W   = 4;

    // Control that travels with a vertical sum into the horizontal window
    typedef struct packed {
        logic valid;
        logic row_start;
    } t_beat;

endpackage

// ===== hw/rtl/bbds_vsum.sv =====
// Line store memory with read-modify-write and per-column vertical sum.
module bbds_vsum #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_acc,
    input  logic [bbds_pkg::ALPHA_W-1:0]        i_alpha,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_col,
    input  logic [$clog2(2*RADIUS)-1:0]         i_slot,
    input  logic [$clog2(2*RADIUS+2)-1:0]       i_row,
    output bbds_pkg::t_beat                     o_beat,
    output logic [$clog2((2*RADIUS+1)*255+1)-1:0] o_vsum
);

    localparam int AW     = bbds_pkg::ALPHA_W;
    localparam int SR     = 2 * RADIUS;
    localparam int K      = SR + 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int SLOT_W = $clog2(SR);
    localparam int ROW_W  = $clog2(K + 1);
    localparam int VS_W   = $clog2(K * 255 + 1);
    localparam int WORD_W = SR * AW;
    localparam int D_W    = (ROW_W > SLOT_W + 1) ? ROW_W : SLOT_W + 1;

    // One word per column holds that column of every stored row
    logic [WORD_W-1:0] mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rd_data;

    logic              r_s1_valid;
    logic [AW-1:0]     r_alpha;
    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;
    logic [ROW_W-1:0]  r_row;
    logic              r_hit;
    logic [WORD_W-1:0] r_fwd;
    logic [W_W-1:0]    r_fill [SR];

    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] wr_word;
    logic [VS_W-1:0]   vsum;

    bbds_pkg::t_beat   r_beat;
    logic [VS_W-1:0]   r_vsum;

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd_data <= mem[i_col];
        end
        if (r_s1_valid) begin
            mem[r_col] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_acc;
        end
        if (i_acc) begin
            r_alpha <= i_alpha;
            r_col   <= i_col;
            r_slot  <= i_slot;
            r_row   <= i_row;
            // Same column written at this edge: memory returns stale data
            r_hit   <= r_s1_valid && (r_col == i_col);
            r_fwd   <= wr_word;
        end
    end

    // Columns written per ring row since reset; entries past it were never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SR; s++) begin
                r_fill[s] <= '0;
            end
        end else if (r_s1_valid && (W_W'(r_col) >= r_fill[r_slot])) begin
            r_fill[r_slot] <= W_W'(r_col) + W_W'(1);
        end
    end

    // The current ring row holds the row furthest above before it is overwritten
    always_comb begin
        logic [D_W-1:0] ring_dist;
        logic           keep;
        rd_word = r_hit ? r_fwd : r_rd_data;
        vsum    = VS_W'(r_alpha);
        wr_word = rd_word;
        for (int s = 0; s < SR; s++) begin
            if (D_W'(r_slot) > D_W'(s)) begin
                ring_dist = D_W'(r_slot) - D_W'(s);
            end else begin
                ring_dist = D_W'(r_slot) + D_W'(SR) - D_W'(s);
            end
            keep = (ring_dist <= D_W'(r_row)) && (W_W'(r_col) < r_fill[s]);
            if (keep) begin
                vsum = vsum + VS_W'(rd_word[s*AW +: AW]);
            end
            if (SLOT_W'(s) == r_slot) begin
                wr_word[s*AW +: AW] = r_alpha;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= r_s1_valid;
        end
        r_beat.row_start <= (r_col == '0);
        r_vsum           <= vsum;
    end

    assign o_beat = r_beat;
    assign o_vsum = r_vsum;

endmodule

// ===== hw/rtl/bbds_hwin.sv =====
// Horizontal sliding window over the last column sums of the row.
module bbds_hwin #(
    parameter int RADIUS = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  bbds_pkg::t_beat                             i_beat,
    input  logic [$clog2((2*RADIUS+1)*255+1)-1:0]       i_vsum,
    output logic                                        o_valid,
    output logic [$clog2((2*RADIUS+1)*(2*RADIUS+1)*255+1)-1:0] o_wsum
);

    localparam int K    = 2 * RADIUS + 1;
    localparam int VS_W = $clog2(K * 255 + 1);
    localparam int WS_W = $clog2(K * K * 255 + 1);

    logic [VS_W-1:0] r_cw [K];
    logic [WS_W-1:0] r_wsum;
    logic            r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wsum  <= '0;
            for (int i = 0; i < K; i++) begin
                r_cw[i] <= '0;
            end
        end else begin
            r_valid <= i_beat.valid;
            if (i_beat.valid) begin
                r_cw[0] <= i_vsum;
                // Drop the window at row start: columns left of zero count as zero
                for (int i = 1; i < K; i++) begin
                    r_cw[i] <= i_beat.row_start ? '0 : r_cw[i-1];
                end
                if (i_beat.row_start) begin
                    r_wsum <= WS_W'(i_vsum);
                end else begin
                    r_wsum <= r_wsum + WS_W'(i_vsum) - WS_W'(r_cw[K-1]);
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_wsum  = r_wsum;

endmodule

// ===== hw/rtl/bbds_cdiv.sv =====
// Rounded-up division of the window sum by the window area, then clamp.
module bbds_cdiv #(
    parameter int RADIUS = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic [$clog2((2*RADIUS+1)*(2*RADIUS+1)*255+1)-1:0] i_sum,
    input  logic [bbds_pkg::ALPHA_W-1:0]                i_ceiling,
    output logic                                        o_valid,
    output logic [bbds_pkg::ALPHA_W-1:0]                o_alpha
);

    localparam int AW    = bbds_pkg::ALPHA_W;
    localparam int K     = 2 * RADIUS + 1;
    localparam int AREA  = K * K;
    localparam int S_W   = $clog2(AREA * 255 + 1);
    localparam int MUL_M = (2 ** S_W) / AREA;
    localparam int M_W   = $clog2(MUL_M + 1);
    localparam int P_W   = S_W + M_W;

    logic [P_W-1:0] prod;
    logic [AW-1:0]  r_qe;
    logic [S_W-1:0] r_sum;
    logic           r_valid;

    logic [S_W-1:0] qa;
    logic [S_W-1:0] rem;
    logic [1:0]     step;
    logic [AW:0]    q;
    logic [AW-1:0]  res;

    // Reciprocal estimate: floor of sum/area, or one below it
    assign prod = P_W'(i_sum) * P_W'(MUL_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_qe  <= prod[S_W +: AW];
        r_sum <= i_sum;
    end

    // Remainder lies below twice the area; fold in the correction and the round-up
    always_comb begin
        qa  = S_W'(r_qe) * S_W'(AREA);
        rem = r_sum - qa;
        if (rem == '0) begin
            step = 2'd0;
        end else if (rem <= S_W'(AREA)) begin
            step = 2'd1;
        end else begin
            step = 2'd2;
        end
        q   = {1'b0, r_qe} + (AW+1)'(step);
        res = q[AW-1:0];
    end

    assign o_valid = r_valid;
    assign o_alpha = (res > i_ceiling) ? i_ceiling : res;

endmodule

// ===== hw/rtl/bbds_fifo.sv =====
// Small output queue that holds finished results while the consumer stalls.
module bbds_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [bbds_pkg::ALPHA_W-1:0] i_data,
    input  logic                         i_pop,
    output logic                         o_valid,
    output logic [bbds_pkg::ALPHA_W-1:0] o_data
);

    logic [bbds_pkg::ALPHA_W-1:0]    r_buf [bbds_pkg::FIFO_DEPTH];
    logic [bbds_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [bbds_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [bbds_pkg::CREDIT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];

endmodule

// ===== hw/rtl/box_blur_drop_shadow.sv =====
// Top level of the box blur drop shadow filter: position tracking, config, credits.
// Throughput: one item per clock when not stalled; the line store is one read and one write per cycle.
// Path: an accepted item passes the memory read, vertical sum, window update,
//   reciprocal divide and output queue before its result is offered.
// Reset: control state, window and per-row fill counts clear synchronously; no
//   clearing pass; line store entries are not cleared, and fill counts mask unwritten ones.
module box_blur_drop_shadow #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bbds_pkg::ALPHA_W-1:0]    i_alpha,
    input  logic                            i_frame_start,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bbds_pkg::ALPHA_W-1:0]    o_shadow_alpha,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bbds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bbds_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SR     = 2 * RADIUS;
    localparam int K      = SR + 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int SLOT_W = $clog2(SR);
    localparam int ROW_W  = $clog2(K + 1);
    localparam int VS_W   = $clog2(K * 255 + 1);
    localparam int WS_W   = $clog2(K * K * 255 + 1);
    localparam int CMP_W  = (W_W > bbds_pkg::CFG_DATA_W) ? W_W : bbds_pkg::CFG_DATA_W;

    // Configuration registers
    logic [bbds_pkg::CFG_DATA_W-1:0] r_frame_width;
    logic [bbds_pkg::ALPHA_W-1:0]    r_clamp;

    // Raster position: column, rows seen this frame (saturating), ring row
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [SLOT_W-1:0] r_slot;

    // Items accepted and not yet taken at the output
    logic [bbds_pkg::CREDIT_W-1:0] r_credit;

    logic              in_acc;
    logic              out_acc;
    logic              cfg_we;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [SLOT_W-1:0] cur_slot;
    logic [CMP_W-1:0]  fw_ext;
    logic [CMP_W-1:0]  w_eff;
    logic              row_last;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [SLOT_W-1:0] n_slot;

    bbds_pkg::t_beat   beat;
    logic [VS_W-1:0]   vsum;
    logic              wsum_valid;
    logic [WS_W-1:0]   wsum;
    logic              res_valid;
    logic [bbds_pkg::ALPHA_W-1:0] res_alpha;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Hold off input only when every queue slot is spoken for
    assign o_in_stall = (r_credit == bbds_pkg::CREDIT_W'(bbds_pkg::FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= bbds_pkg::FRAME_WIDTH_RST;
            r_clamp       <= bbds_pkg::CLAMP_RST;
        end else if (cfg_we) begin
            if (i_cfg_index == bbds_pkg::CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end else if (i_cfg_index == bbds_pkg::CFG_CLAMP_CEILING) begin
                r_clamp <= i_cfg_data[bbds_pkg::ALPHA_W-1:0];
            end
        end
    end

    // Frame start restarts position before this item is used
    always_comb begin
        cur_col  = i_frame_start ? '0 : r_col;
        cur_row  = i_frame_start ? '0 : r_row;
        cur_slot = i_frame_start ? '0 : r_slot;

        // Width zero acts as one; widths beyond the line store act as its size
        fw_ext = CMP_W'(r_frame_width);
        if (fw_ext == '0) begin
            w_eff = CMP_W'(1);
        end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        row_last = (CMP_W'(cur_col) + CMP_W'(1)) >= w_eff;

        if (row_last) begin
            n_col  = '0;
            n_row  = (cur_row < ROW_W'(K)) ? cur_row + 1'b1 : cur_row;
            n_slot = (cur_slot == SLOT_W'(SR - 1)) ? '0 : cur_slot + 1'b1;
        end else begin
            n_col  = cur_col + 1'b1;
            n_row  = cur_row;
            n_slot = cur_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
            r_credit <= '0;
        end else begin
            if (in_acc) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_slot <= n_slot;
            end
            case ({in_acc, out_acc})
                2'b10:   r_credit <= r_credit + 1'b1;
                2'b01:   r_credit <= r_credit - 1'b1;
                default: r_credit <= r_credit;
            endcase
        end
    end

    // Read the column word at accept, add rows above, write the new sample back
    bbds_vsum #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_vsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_alpha (i_alpha),
        .i_col   (cur_col),
        .i_slot  (cur_slot),
        .i_row   (cur_row),
        .o_beat  (beat),
        .o_vsum  (vsum)
    );

    // Slide the column sums across the row
    bbds_hwin #(
        .RADIUS (RADIUS)
    ) u_hwin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .i_vsum  (vsum),
        .o_valid (wsum_valid),
        .o_wsum  (wsum)
    );

    // Average with round-up, then clamp to the ceiling
    bbds_cdiv #(
        .RADIUS (RADIUS)
    ) u_cdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (wsum_valid),
        .i_sum     (wsum),
        .i_ceiling (r_clamp),
        .o_valid   (res_valid),
        .o_alpha   (res_alpha)
    );

    // Park results until the consumer takes them
    bbds_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_alpha),
        .i_pop   (out_acc),
        .o_valid (o_out_valid),
        .o_data  (o_shadow_alpha)
    );

    // Every accepted item reaches the queue after the read, vertical sum, window and divide registers
    a_item_reaches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##4 res_valid)
        else $error("accepted item did not produce a result on time");

    // A result in flight always holds a credit, so the queue cannot overflow
    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (r_credit != '0))
        else $error("result produced without a matching credit");

    // Row count saturates and the ring row stays inside the store
    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ((r_row <= ROW_W'(K)) && (r_slot <= SLOT_W'(SR - 1))))
        else $error("row count or ring row out of range");

endmodule

// ===== tb/sv/box_blur_drop_shadow_tb.sv =====
// Self-checking testbench for the box blur drop shadow filter.
`timescale 1ns / 100ps

module box_blur_drop_shadow_tb;

    localparam int MAX_W       = 1024;
    localparam int BLUR_RADIUS = 4;
    localparam int STORE_ROWS  = 2 * BLUR_RADIUS;
    localparam int WIN         = 2 * BLUR_RADIUS + 1;
    localparam int AREA        = WIN * WIN;
    localparam int FULL_ALPHA  = 255;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Index past the register list: a write there must change nothing
    localparam logic [bbds_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // Content of the source area of a generated frame
    typedef enum int {
        FILL_RANDOM,
        FILL_SOLID,
        FILL_BINARY,
        FILL_FAINT
    } t_fill;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [bbds_pkg::ALPHA_W-1:0]    i_alpha;
    logic                            i_frame_start;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [bbds_pkg::ALPHA_W-1:0]    o_shadow_alpha;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [bbds_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bbds_pkg::CFG_DATA_W-1:0] i_cfg_data;

    box_blur_drop_shadow #(
        .MAX_WIDTH (MAX_W),
        .RADIUS    (BLUR_RADIUS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_alpha        (i_alpha),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_shadow_alpha (o_shadow_alpha),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow predictor: mirror of the filter state at the block's widths
    // ------------------------------------------------------------------
    logic [10:0] cfg_width;
    logic [7:0]  cfg_ceiling;
    logic [7:0]  stored_rows [STORE_ROWS][MAX_W];  // ring of the rows above
    logic [2:0]  ring_row;                         // ring row the current row fills
    logic [11:0] col_sums [WIN];                   // vertical sums, newest first
    logic [14:0] box_total;
    logic [9:0]  col_at;
    logic [3:0]  rows_done;                        // saturates at WIN

    logic [7:0]  shadow_due [$];                   // predicted shadow alphas in order

    int          in_idle_pct;
    int          out_stall_pct;
    int          hold_request;
    int          hold_left;
    int          items_sent;
    int          results_seen;
    int          mismatches;
    int unsigned cycle_count;

    // Zero is taken as one, anything past the line store as the full width
    function automatic int unsigned active_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic logic [7:0] blur_shadow(input logic [7:0] a, input logic fs);
        int unsigned w;
        int unsigned vsum;
        int unsigned deficit;
        int unsigned shade;
        int          d;
        int          i;
        logic [2:0]  slot;
        // a frame start restarts the position before this item is used
        if (fs) begin
            col_at    = '0;
            rows_done = '0;
            ring_row  = '0;
        end
        w = active_width();
        // vertical sum: only rows written in this frame count
        vsum = a;
        for (d = 1; d <= STORE_ROWS; d++) begin
            if (d <= rows_done) begin
                slot = ring_row - 3'(d);
                vsum += stored_rows[slot][col_at];
            end
        end
        stored_rows[ring_row][col_at] = a;
        // columns left of column zero are zero
        if (col_at == 0) begin
            col_sums  = '{default: '0};
            box_total = '0;
        end
        box_total = 15'(int'(box_total) - int'(col_sums[WIN-1]) + int'(vsum));
        for (i = WIN - 1; i > 0; i--) col_sums[i] = col_sums[i-1];
        col_sums[0] = 12'(vsum);
        // ceil(sum / area) written through the deficit form
        deficit = AREA * FULL_ALPHA - box_total;
        shade   = FULL_ALPHA - deficit / AREA;
        if (shade > cfg_ceiling) shade = cfg_ceiling;
        // advance; a narrowed width wraps as soon as the next column reaches it
        if (col_at + 1 >= w) begin
            col_at = '0;
            if (rows_done < WIN) rows_done++;
            ring_row++;
        end else begin
            col_at++;
        end
        return 8'(shade);
    endfunction

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and the run limit
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatches < 100)
            $display("mismatch on result %0d: %s, want %0d got %0d",
                     results_seen, what, want, got);
        mismatches++;
    endtask

    // Compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_result
        logic [7:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (shadow_due.size() == 0) begin
                report_mismatch("result with no item pending", -1, o_shadow_alpha);
            end else begin
                want = shadow_due.pop_front();
                if (o_shadow_alpha !== want)
                    report_mismatch("shadow_alpha", want, o_shadow_alpha);
            end
            results_seen++;
        end
    end

    // Stall the output at random; a hold request stalls it for a long stretch
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Item and register traffic
    // ------------------------------------------------------------------

    // Offer one item and hold it until taken; valid stays high on return
    task automatic send_item(input logic [7:0] a, input logic fs);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < in_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_alpha       <= a;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall);
        shadow_due.push_back(blur_shadow(a, fs));
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow_due.size() != 0);
    endtask

    // Write one register; valid stays high so writes can go back to back
    task automatic write_reg(input logic [bbds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bbds_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == bbds_pkg::CFG_FRAME_WIDTH) cfg_width = data;
        else if (idx == bbds_pkg::CFG_CLAMP_CEILING) cfg_ceiling = data[7:0];
    endtask

    task automatic apply_settings(input logic [bbds_pkg::CFG_DATA_W-1:0] width,
                                  input logic [bbds_pkg::CFG_DATA_W-1:0] ceiling);
        write_reg(bbds_pkg::CFG_FRAME_WIDTH, width);
        write_reg(bbds_pkg::CFG_CLAMP_CEILING, ceiling);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [10:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 11'($urandom_range(9, 20));
        if (r < 88) return 11'($urandom_range(21, 32));
        return 11'($urandom_range(0, 8));
    endfunction

    // Send a padded frame in raster order: source content in the top left,
    // zero in the eight trailing columns and rows. Stop early if asked.
    task automatic send_frame(input int rows, input t_fill fill, input int stop_after,
                              input logic mark_start);
        int          r;
        int          c;
        int          n;
        int unsigned w;
        logic [7:0]  a;
        w = active_width();
        n = 0;
        for (r = 0; r < rows; r++) begin
            for (c = 0; c < w; c++) begin
                if (n == stop_after) return;
                a = 8'd0;
                if ((w <= STORE_ROWS || c < w - STORE_ROWS) &&
                    (rows <= STORE_ROWS || r < rows - STORE_ROWS)) begin
                    case (fill)
                        FILL_RANDOM: a = 8'($urandom_range(0, 255));
                        FILL_SOLID:  a = 8'(FULL_ALPHA);
                        FILL_BINARY: a = $urandom_range(0, 1) ? 8'(FULL_ALPHA) : 8'd0;
                        default:     a = 8'($urandom_range(0, 3));
                    endcase
                end
                send_item(a, mark_start && n == 0);
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values of width and ceiling, solid alpha from the first item
    task automatic test_reset_values();
        int n;
        for (n = 0; n < 6; n++) send_item(8'hFF, n == 0);
    endtask

    // Width zero acts as one: every item is a row of its own, so the sum
    // builds up vertically and then slides; a frame start masks old rows
    task automatic test_degenerate_width();
        int n;
        wait_results_drained();
        apply_settings(11'd0, 11'd255);
        for (n = 0; n < 10; n++) send_item(8'hFF, n == 0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
    endtask

    // Ceiling at zero and at full scale; a write past the register list
    // must not disturb either register
    task automatic test_ceiling_limits();
        int n;
        wait_results_drained();
        apply_settings(11'd9, 11'd0);
        for (n = 0; n < 3; n++) send_item(8'hFF, n == 0);
        wait_results_drained();
        write_reg(CFG_IDX_SPARE, 11'h7FF);
        write_reg(bbds_pkg::CFG_CLAMP_CEILING, 11'h7FF);
        i_cfg_valid <= 1'b0;
        for (n = 0; n < 3; n++) send_item(8'hFF, 1'b0);
    endtask

    // Hold the output off while items keep coming so the block fills and
    // stalls its input, then pause the sender until everything has returned
    task automatic test_backpressure();
        int n;
        wait_results_drained();
        apply_settings(11'd16, 11'(bbds_pkg::CLAMP_RST));
        hold_request = 150;
        for (n = 0; n < 64; n++) send_item(8'($urandom_range(0, 255)), n == 0);
        wait_results_drained();
        for (n = 0; n < 24; n++) send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Width above the line store acts as the full store width; cover the
    // last column and the wrap into the next row
    task automatic test_full_width();
        wait_results_drained();
        apply_settings(11'h7FF, 11'd255);
        send_frame(2, FILL_RANDOM, MAX_W + 8, 1'b1);
    endtask

    // Mostly well-formed frames with random settings and content; some cut
    // short with the width changed mid-row, some plain noise
    task automatic test_random_frames(input int quota);
        int    goal;
        int    kind;
        int    rows;
        int    stop_at;
        int    r;
        logic [7:0] ceil_pick;
        t_fill fill;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            wait_results_drained();
            r = $urandom_range(0, 99);
            if (r < 30) ceil_pick = bbds_pkg::CLAMP_RST;
            else if (r < 50) ceil_pick = 8'd255;
            else if (r < 60) ceil_pick = 8'd0;
            else ceil_pick = 8'($urandom_range(0, 255));
            apply_settings(pick_width(), {3'($urandom_range(0, 7)), ceil_pick});
            kind = $urandom_range(0, 99);
            fill = t_fill'($urandom_range(0, 3));
            rows = $urandom_range(9, 12);
            // run past the frame height now and then, on narrow frames only
            if (active_width() <= 20 && $urandom_range(0, 4) == 0)
                rows = $urandom_range(18, 22);
            if (kind < 70) begin
                send_frame(rows, fill, -1, 1'b1);
            end else if (kind < 85) begin
                stop_at = $urandom_range(1, rows * active_width() - 1);
                send_frame(rows, fill, stop_at, 1'b1);
                wait_results_drained();
                write_reg(bbds_pkg::CFG_FRAME_WIDTH, pick_width());
                i_cfg_valid <= 1'b0;
                send_frame($urandom_range(2, 4), fill, -1, 1'b0);
            end else begin
                repeat ($urandom_range(20, 120))
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int row_i;
        int col_i;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_alpha       <= '0;
        i_frame_start <= 1'b0;
        i_out_stall   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= bbds_pkg::CFG_FRAME_WIDTH;
        i_cfg_data    <= '0;

        cfg_width     = bbds_pkg::FRAME_WIDTH_RST;
        cfg_ceiling   = bbds_pkg::CLAMP_RST;
        // model line store starts all zero
        for (row_i = 0; row_i < STORE_ROWS; row_i++)
            for (col_i = 0; col_i < MAX_W; col_i++)
                stored_rows[row_i][col_i] = '0;
        col_sums      = '{default: '0};
        box_total     = '0;
        col_at        = '0;
        rows_done     = '0;
        ring_row      = '0;
        hold_request  = 0;
        hold_left     = 0;
        items_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        cycle_count   = 0;

        // sender idles rarely, receiver stalls often
        in_idle_pct   = 10;
        out_stall_pct = 71;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_degenerate_width();
        test_ceiling_limits();
        test_random_frames(220);

        // swap: sender idles often, receiver rarely
        in_idle_pct   = 71;
        out_stall_pct = 10;
        test_random_frames(220);

        // full rate on both sides
        in_idle_pct   = 0;
        out_stall_pct = 0;
        test_backpressure();
        test_random_frames(220);
        test_full_width();

        wait_results_drained();
        repeat (12) @(posedge i_clk);
        if (mismatches == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
